// ===== src/wtsh_pkg.sv =====
`default_nettype none
package wtsh_pkg;

	// candidates scored per frame, the rest only close the frame
	localparam int MAX_CAND = 16;
	localparam int SEEN_W = $clog2(MAX_CAND + 1);
	localparam int IDX_W = 6;

	// depth of the queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// image centre in hundredths of a pixel
	localparam logic [15:0] CX0 = 16'd32000;
	localparam logic [15:0] CY0 = 16'd24000;
	// rounding and scale of the centre distance (400 px in hundredths, Q16 root)
	localparam logic [32:0] RND_C = 33'd20000;
	localparam logic [15:0] DIV_C = 16'd40000;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	// x / 10 as multiply by reciprocal, exact over 16 bits
	localparam logic [15:0] TEN_RECIP = 16'd52429;
	localparam int TEN_SHIFT = 19;

	// iteration counts of the shared root and divide unit
	localparam logic [5:0] SQRT_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'd17;

	typedef enum logic [2:0] {
		CFG_W_CENTER = 3'd0,
		CFG_W_DISTANCE = 3'd1,
		CFG_W_STABILITY = 3'd2,
		CFG_MARGIN = 3'd3,
		CFG_CAP = 3'd4,
		CFG_RANGE_LIM = 3'd5,
		CFG_TIMEOUT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] wt_ctr;
		logic [15:0] wt_dist;
		logic [15:0] wt_stab;
		logic [15:0] margin;
		logic [7:0] cap;
		logic [15:0] lim;
		logic [15:0] timeout;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic kind;
		logic last;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] rng;
		logic [31:0] now;
		logic [15:0] tag;
	} fe_word_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
		logic [32:0] opnd;
		logic [15:0] divisor;
	} ar_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] res;
	} ar_rsp_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_CLASS,
		B_SQX,
		B_SQY,
		B_RT_GO,
		B_RT_W,
		B_DC_GO,
		B_DC_W,
		B_DN_GO,
		B_DN_W,
		B_DS_GO,
		B_DS_W,
		B_MC,
		B_MD,
		B_MS,
		B_CMP,
		B_FINAL,
		B_EMIT
	} bk_state_t;

endpackage
`default_nettype wire

// ===== src/wtsh_front.sv =====
`default_nettype none
module wtsh_front import wtsh_pkg::*; (
	input wire logic in_valid,
	output logic in_ready,
	input wire logic kind,
	input wire logic [15:0] center_x,
	input wire logic [15:0] center_y,
	input wire logic [15:0] range_mm,
	input wire logic last_in_frame,
	input wire logic [31:0] frame_time_ms,
	input wire logic q_full,
	output logic q_push,
	output fe_word_t q_word
);

	logic [31:0] recip_prod;

	// tag = floor(x / 10) + y, by reciprocal
	assign recip_prod = center_x * TEN_RECIP;

	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready;

	always_comb begin
		q_word.kind = kind;
		q_word.last = last_in_frame;
		q_word.cx = center_x;
		q_word.cy = center_y;
		q_word.rng = range_mm;
		q_word.now = frame_time_ms;
		q_word.tag = 16'(recip_prod >> TEN_SHIFT) + center_y;
	end

endmodule
`default_nettype wire

// ===== src/wtsh_queue.sv =====
`default_nettype none
module wtsh_queue import wtsh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input fe_word_t push_word,
	output logic full,
	input wire logic pop,
	output logic not_empty,
	output fe_word_t head
);

	fe_word_t slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_PTR_W:0] cnt_q;

	assign full = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/wtsh_arith.sv =====
`default_nettype none
module wtsh_arith import wtsh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input ar_req_t req,
	output ar_rsp_t rsp
);

	logic [34:0] rem_q, rem_sh, trial, diff;
	logic [31:0] acc_q, rad_q;
	logic [15:0] div_q;
	logic [5:0] cnt_q;
	logic sqrt_q, busy_q, done_q, ge;

	// one step: two radicand bits for the root, one numerator bit for the divide
	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[32:0], rad_q[31:30]};
			trial = {1'b0, acc_q, 2'b01};
		end else begin
			rem_sh = {rem_q[33:0], rad_q[31]};
			trial = {19'd0, div_q};
		end
		ge = (rem_sh >= trial);
		diff = rem_sh - trial;
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res = acc_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt_mode;
			div_q <= req.divisor;
			acc_q <= '0;
			if (req.sqrt_mode) begin
				rem_q <= '0;
				rad_q <= req.opnd[31:0];
			end else begin
				// top bits are below the divisor, so the quotient fits 17 bits
				rem_q <= {19'd0, req.opnd[32:17]};
				rad_q <= {req.opnd[16:0], 15'd0};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff : rem_sh;
			acc_q <= {acc_q[30:0], ge};
			rad_q <= sqrt_q ? {rad_q[29:0], 2'b00} : {rad_q[30:0], 1'b0};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.sqrt_mode ? SQRT_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("start while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0) else $error("step count left over");
`endif

endmodule
`default_nettype wire

// ===== src/wtsh_back.sv =====
`default_nettype none
module wtsh_back import wtsh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input cfg_t cfg,
	input wire logic q_valid,
	input fe_word_t q_word,
	output logic q_pop,
	output ar_req_t ar_req,
	input ar_rsp_t ar_rsp,
	output logic out_valid,
	input wire logic out_ready,
	output logic target_valid,
	output logic [5:0] target_index,
	output logic [15:0] target_tag,
	output logic [21:0] target_score,
	output logic [15:0] frames_tracked
);

	bk_state_t st_q, st_d;
	fe_word_t cur_q;
	logic cur_hold_q;
	logic [34:0] acc_q, acc_rnd;
	logic [16:0] sc_q, sn_q, ss_q;
	logic holding_q;
	logic [15:0] held_tag_q, held_frames_q, frames_next;
	logic [31:0] prev_time_q, gap;
	logic [21:0] run_best_q, score;
	logic [IDX_W-1:0] run_idx_q;
	logic [15:0] run_tag_q;
	logic [SEEN_W-1:0] seen_q;
	logic pend_v_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic [15:0] pend_tag_q, pend_fr_q;
	logic [21:0] pend_score_q;
	logic out_valid_q, out_load;
	logic [15:0] dx_abs, dy_abs, frames_eff, rng_min;
	logic [7:0] stab_s;
	logic [16:0] mult_a, mult_b;
	logic [33:0] prod;
	logic [22:0] bar;
	logic win, is_cur, seen_full;

	// centre offsets, clamped stability and range, held-tag match and candidate limit
	always_comb begin
		dx_abs = (cur_q.cx >= CX0) ? cur_q.cx - CX0 : CX0 - cur_q.cx;
		dy_abs = (cur_q.cy >= CY0) ? cur_q.cy - CY0 : CY0 - cur_q.cy;
		frames_eff = cur_hold_q ? held_frames_q : 16'd0;
		stab_s = (frames_eff < {8'd0, cfg.cap}) ? frames_eff[7:0] : cfg.cap;
		rng_min = (cur_q.rng < cfg.lim) ? cur_q.rng : cfg.lim;
		is_cur = holding_q && (q_word.tag == held_tag_q);
		seen_full = (seen_q >= SEEN_W'(MAX_CAND));
	end

	// shared multiplier
	always_comb begin
		case (st_q)
			B_SQX: begin
				mult_a = {1'b0, dx_abs};
				mult_b = {1'b0, dx_abs};
			end
			B_SQY: begin
				mult_a = {1'b0, dy_abs};
				mult_b = {1'b0, dy_abs};
			end
			B_MC: begin
				mult_a = {1'b0, cfg.wt_ctr};
				mult_b = sc_q;
			end
			B_MD: begin
				mult_a = {1'b0, cfg.wt_dist};
				mult_b = sn_q;
			end
			B_MS: begin
				mult_a = {1'b0, cfg.wt_stab};
				mult_b = ss_q;
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
		prod = mult_a * mult_b;
	end

	// rounded score and the bar it must beat, frame gap and next tracked-frame count
	always_comb begin
		acc_rnd = acc_q + 35'd2048;
		score = acc_rnd[33:12];
		bar = {1'b0, run_best_q} + ((!cur_hold_q && holding_q) ? {7'd0, cfg.margin} : 23'd0);
		win = (seen_q == '0) || ({1'b0, score} > bar);
		gap = cur_q.now - prev_time_q;
		if (holding_q && (run_tag_q == held_tag_q)) begin
			frames_next = (held_frames_q != 16'hFFFF) ? held_frames_q + 1'b1 : held_frames_q;
		end else begin
			frames_next = 16'd1;
		end
	end

	assign out_load = (st_q == B_EMIT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (q_valid) st_d = B_CLASS;
			B_CLASS: begin
				if (cur_q.kind) begin
					st_d = B_EMIT;
				end else if (seen_full) begin
					st_d = cur_q.last ? B_FINAL : B_IDLE;
				end else begin
					st_d = B_SQX;
				end
			end
			B_SQX: st_d = B_SQY;
			B_SQY: st_d = B_RT_GO;
			B_RT_GO: st_d = B_RT_W;
			B_RT_W: if (ar_rsp.done) st_d = B_DC_GO;
			B_DC_GO: st_d = B_DC_W;
			B_DC_W: if (ar_rsp.done) st_d = B_DN_GO;
			B_DN_GO: st_d = B_DN_W;
			B_DN_W: if (ar_rsp.done) st_d = B_DS_GO;
			B_DS_GO: st_d = B_DS_W;
			B_DS_W: if (ar_rsp.done) st_d = B_MC;
			B_MC: st_d = B_MD;
			B_MD: st_d = B_MS;
			B_MS: st_d = B_CMP;
			B_CMP: st_d = cur_q.last ? B_FINAL : B_IDLE;
			B_FINAL: st_d = B_EMIT;
			B_EMIT: if (out_load) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	// state outputs: queue pop and unit requests
	always_comb begin
		q_pop = 1'b0;
		ar_req.start = 1'b0;
		ar_req.sqrt_mode = 1'b0;
		ar_req.opnd = '0;
		ar_req.divisor = '0;
		case (st_q)
			B_IDLE: q_pop = q_valid;
			B_RT_GO: begin
				ar_req.start = 1'b1;
				ar_req.sqrt_mode = 1'b1;
				ar_req.opnd = {1'b0, acc_q[31:0]};
			end
			B_DC_GO: begin
				ar_req.start = 1'b1;
				ar_req.opnd = {1'b0, acc_q[31:0]} + RND_C;
				ar_req.divisor = DIV_C;
			end
			B_DN_GO: begin
				ar_req.start = 1'b1;
				ar_req.opnd = {1'b0, rng_min, 16'd0} + {17'd0, 1'b0, cfg.lim[15:1]};
				ar_req.divisor = cfg.lim;
			end
			B_DS_GO: begin
				ar_req.start = 1'b1;
				ar_req.opnd = {9'd0, stab_s, 16'd0} + {26'd0, cfg.cap[7:1]};
				ar_req.divisor = {8'd0, cfg.cap};
			end
			default: begin
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_word;
			cur_hold_q <= is_cur;
		end
		case (st_q)
			B_SQX: acc_q <= {1'b0, prod};
			B_SQY: acc_q <= acc_q + {1'b0, prod};
			B_RT_W: if (ar_rsp.done) acc_q <= {3'd0, ar_rsp.res};
			B_MC: acc_q <= {1'b0, prod};
			B_MD: acc_q <= acc_q + {1'b0, prod};
			B_MS: acc_q <= acc_q + {1'b0, prod};
			default: begin
			end
		endcase
		// centre score saturates at zero
		if (st_q == B_DC_W && ar_rsp.done) begin
			sc_q <= (ar_rsp.res > {15'd0, ONE_Q16}) ? 17'd0 : ONE_Q16 - ar_rsp.res[16:0];
		end
		// invalid range or zero limit gives no nearness
		if (st_q == B_DN_W && ar_rsp.done) begin
			sn_q <= (cur_q.rng == '0 || cfg.lim == '0) ? 17'd0 : ONE_Q16 - ar_rsp.res[16:0];
		end
		// zero cap counts as fully stable
		if (st_q == B_DS_W && ar_rsp.done) begin
			ss_q <= (cfg.cap == '0) ? ONE_Q16 : ar_rsp.res[16:0];
		end
		if (out_load) begin
			target_valid <= pend_v_q;
			target_index <= pend_idx_q;
			target_tag <= pend_tag_q;
			target_score <= pend_score_q;
			frames_tracked <= pend_fr_q;
		end
	end

	// frame and target state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			holding_q <= 1'b0;
			held_tag_q <= '0;
			held_frames_q <= '0;
			prev_time_q <= '0;
			run_best_q <= '0;
			run_idx_q <= '0;
			run_tag_q <= '0;
			seen_q <= '0;
			pend_v_q <= 1'b0;
			pend_idx_q <= '0;
			pend_tag_q <= '0;
			pend_score_q <= '0;
			pend_fr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				// empty frame: drop open frame, check the gap
				B_CLASS: begin
					if (cur_q.kind) begin
						run_best_q <= '0;
						run_idx_q <= '0;
						run_tag_q <= '0;
						seen_q <= '0;
						if (holding_q && gap > {16'd0, cfg.timeout}) begin
							holding_q <= 1'b0;
							held_tag_q <= '0;
							held_frames_q <= '0;
						end
						prev_time_q <= cur_q.now;
						pend_v_q <= 1'b0;
						pend_idx_q <= '0;
						pend_tag_q <= '0;
						pend_score_q <= '0;
						pend_fr_q <= '0;
					end
				end
				B_CMP: begin
					if (win) begin
						run_best_q <= score;
						run_idx_q <= IDX_W'(seen_q);
						run_tag_q <= cur_q.tag;
					end
					seen_q <= seen_q + 1'b1;
				end
				// close the frame: keep or switch
				B_FINAL: begin
					holding_q <= 1'b1;
					held_tag_q <= run_tag_q;
					held_frames_q <= frames_next;
					prev_time_q <= cur_q.now;
					pend_v_q <= 1'b1;
					pend_idx_q <= run_idx_q;
					pend_tag_q <= run_tag_q;
					pend_score_q <= run_best_q;
					pend_fr_q <= frames_next;
					run_best_q <= '0;
					run_idx_q <= '0;
					run_tag_q <= '0;
					seen_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(MAX_CAND)) else $error("candidate count overrun");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !target_valid |-> target_index == '0 && target_tag == '0
		&& target_score == '0 && frames_tracked == '0) else $error("empty word not zero");
	a_hold_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && pend_v_q |=> holding_q && held_tag_q == target_tag)
		else $error("held tag differs from emitted tag");
`endif

endmodule
`default_nettype wire

// ===== src/weighted_target_select_hysteresis.sv =====
`default_nettype none
// channel  direction  handshake             payload
// in       input      in_valid/in_ready     kind, center_x, center_y, range_mm,
//                                           last_in_frame, frame_time_ms
// out      output     out_valid/out_ready   target_valid, target_index, target_tag,
//                                           target_score, frames_tracked
// cfg      input      cfg_we                cfg_index, cfg_data
//
// a candidate's time in the back end is set by the shared
// root/divide unit: 32 root steps and three 17-step divides, plus squares and weighting
// an empty-frame word goes from classification straight to the result register
// a two-word queue sits between front and back end, so input is taken while the back end works
// the result register holds one word; the back end stalls only when a second is ready
// reset clears target state and restores register defaults, no clearing pass
module weighted_target_select_hysteresis import wtsh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic kind,
	input wire logic [15:0] center_x,
	input wire logic [15:0] center_y,
	input wire logic [15:0] range_mm,
	input wire logic last_in_frame,
	input wire logic [31:0] frame_time_ms,
	output logic out_valid,
	input wire logic out_ready,
	output logic target_valid,
	output logic [5:0] target_index,
	output logic [15:0] target_tag,
	output logic [21:0] target_score,
	output logic [15:0] frames_tracked,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	cfg_t cfg_q;
	fe_word_t push_word, head;
	logic q_full, q_push, q_pop, q_valid;
	ar_req_t ar_req;
	ar_rsp_t ar_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wt_ctr <= 16'd4096;
			cfg_q.wt_dist <= 16'd4096;
			cfg_q.wt_stab <= 16'd4096;
			cfg_q.margin <= 16'd6554;
			cfg_q.cap <= 8'd30;
			cfg_q.lim <= 16'd8000;
			cfg_q.timeout <= 16'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_W_CENTER: cfg_q.wt_ctr <= cfg_data;
				CFG_W_DISTANCE: cfg_q.wt_dist <= cfg_data;
				CFG_W_STABILITY: cfg_q.wt_stab <= cfg_data;
				CFG_MARGIN: cfg_q.margin <= cfg_data;
				CFG_CAP: cfg_q.cap <= cfg_data[7:0];
				CFG_RANGE_LIM: cfg_q.lim <= cfg_data;
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wtsh_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.center_x(center_x),
		.center_y(center_y),
		.range_mm(range_mm),
		.last_in_frame(last_in_frame),
		.frame_time_ms(frame_time_ms),
		.q_full(q_full),
		.q_push(q_push),
		.q_word(push_word)
	);

	wtsh_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_word(push_word),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_valid),
		.head(head)
	);

	wtsh_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.req(ar_req),
		.rsp(ar_rsp)
	);

	wtsh_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_word(head),
		.q_pop(q_pop),
		.ar_req(ar_req),
		.ar_rsp(ar_rsp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target_valid(target_valid),
		.target_index(target_index),
		.target_tag(target_tag),
		.target_score(target_score),
		.frames_tracked(frames_tracked)
	);

endmodule
`default_nettype wire
